### sv/hkid_pkg.sv
// Shared types, sizes and helpers for the hot key sketch id allocator.
// No dependencies; hkid_calc, the top level and the testbench files import this package.
package hkid_pkg;

  // The bucket is the low key bits, so NUM_BUCKETS must be a power of two.
  localparam int NUM_BUCKETS = 4096;
  localparam int WAYS        = 4;
  localparam int WAY_W       = 2;
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int KEY_W       = 32;
  localparam int CNT_W       = 32;
  localparam int ID_W        = 12;
  localparam int WGT_W       = 16;
  localparam int THR_W       = 16;
  localparam int TOT_W       = 48;
  localparam int FIFO_DEPTH  = 4096;
  localparam int FIFO_AW     = 12;
  localparam int FILL_W      = 13;
  localparam int DECAY_MUL   = 64881;
  localparam int DECAY_W     = 16;
  localparam longint LIMIT_MUL = longint'(NUM_BUCKETS) * 2560;
  localparam int CLR_N       = (NUM_BUCKETS > FIFO_DEPTH) ? NUM_BUCKETS : FIFO_DEPTH;
  localparam int CLR_W       = $clog2(CLR_N);
  localparam int ROW_W       = WAYS * (KEY_W + CNT_W + ID_W);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    logic [ID_W-1:0]  id;
  } slot_t;

  typedef slot_t [WAYS-1:0] row_t;

  typedef struct packed {
    row_t             row;
    logic             take_id;
    logic             newly_hot;
    logic             is_hot;
    logic [ID_W-1:0]  hot_index;
    logic [KEY_W-1:0] key_echo;
  } calc_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [WGT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W + 1 - WGT_W){1'b0}}, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

### sv/hkid_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module hkid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/hkid_calc.sv
// Bucket update logic: match, weight add, id take, bubble up, miss fill and query lookup.
// Depends on hkid_pkg.
module hkid_calc import hkid_pkg::*; (
  input  row_t             row,
  input  logic             req_type,
  input  logic [KEY_W-1:0] key,
  input  logic [WGT_W-1:0] weight,
  input  logic [CNT_W-1:0] thr,
  input  logic             fifo_empty,
  input  logic [ID_W-1:0]  head_id,
  output calc_t            res
);

  logic [WAYS-1:0]  match;
  logic             hit;
  logic [WAY_W-1:0] mi;
  logic [WAY_W-1:0] j;
  logic             stop;
  logic             empty_found;
  logic [WAY_W-1:0] ei;
  logic             hot_found;
  logic [ID_W-1:0]  hot_id;
  slot_t            mv;

  always_comb begin
    res         = '0;
    res.row     = row;
    hit         = 1'b0;
    mi          = '0;
    empty_found = 1'b0;
    ei          = '0;
    hot_found   = 1'b0;
    hot_id      = '0;
    stop        = 1'b0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      match[i] = (row[i].cnt != '0) && (row[i].key == key);
      if (match[i]) begin
        hit = 1'b1;
        mi  = WAY_W'(i);
      end
      if (row[i].cnt == '0) begin
        empty_found = 1'b1;
        ei          = WAY_W'(i);
      end
      if (match[i] && row[i].id != '0) begin
        hot_found = 1'b1;
        hot_id    = row[i].id;
      end
    end
    mv     = row[mi];
    mv.cnt = sat_add(row[mi].cnt, weight);
    if (mv.cnt >= thr && !fifo_empty && mv.id == '0) begin
      mv.id         = head_id;
      res.take_id   = 1'b1;
    end
    j = mi;
    for (int k = 0; k < WAYS - 1; k++) begin
      if (!stop && j != '0 && mv.cnt > row[j - 1'b1].cnt) begin
        j = j - 1'b1;
      end else begin
        stop = 1'b1;
      end
    end
    if (req_type == REQ_QUERY) begin
      res.take_id   = 1'b0;
      res.is_hot    = hot_found;
      res.hot_index = hot_id;
      res.key_echo  = hot_found ? '0 : key;
    end else if (hit) begin
      res.newly_hot = res.take_id;
      for (int p = 0; p < WAYS; p++) begin
        if (WAY_W'(p) == j) begin
          res.row[p] = mv;
        end else if (p > 0 && WAY_W'(p) > j && WAY_W'(p) <= mi) begin
          res.row[p] = row[p - 1];
        end
      end
    end else begin
      res.take_id = 1'b0;
      if (empty_found) begin
        res.row[ei].key = key;
        res.row[ei].cnt = {{(CNT_W - WGT_W){1'b0}}, weight};
      end else if (row[WAYS-1].id == '0) begin
        res.row[WAYS-1].key = key;
        res.row[WAYS-1].cnt = sat_add(row[WAYS-1].cnt, weight);
      end
    end
  end

endmodule

### sv/hot_key_sketch_id_allocator.sv
// Top level of the hot key sketch id allocator: control, bucket and free-id memories.
// Depends on hkid_pkg, hkid_ram and hkid_calc.
//
// After reset the block clears the bucket memory and loads the free-id list in one
// pass, during which busy is high. A transaction normally reads the bucket row and
// the head of the free-id list, then updates the row in ST_CALC and writes it back
// for an insert; the result strobe comes the cycle after. An insert that starts a
// batch while the running weight total is above the limit first decays the whole
// table, each bucket passing through its read, multiply, per-way release and write
// states, paced by the single read port of the bucket memory and one id release a
// cycle. Results cannot be held off: out_valid is high for exactly one cycle.
module hot_key_sketch_id_allocator import hkid_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic             in_req_type,
  input  logic [KEY_W-1:0] in_key,
  input  logic [WGT_W-1:0] in_weight,
  input  logic             in_batch_first,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  output logic             out_valid,
  output logic             out_newly_hot,
  output logic             out_is_hot,
  output logic [ID_W-1:0]  out_hot_index,
  output logic [KEY_W-1:0] out_key_echo
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_CALC, ST_DEC_RD, ST_DEC_MUL, ST_DEC_REL, ST_DEC_WR, ST_MAIN_RD
  } state_t;

  state_t           state_r;
  logic [THR_W-1:0] thr_r;
  logic [TOT_W-1:0] limit;
  logic [TOT_W-1:0] total_r;
  logic [CLR_W-1:0] clr_r;
  logic [BKT_W-1:0] dec_bkt_r;
  logic [WAY_W-1:0] way_r;
  row_t             dec_row_r;
  logic [FIFO_AW-1:0] head_r;
  logic [FIFO_AW-1:0] tail_r;
  logic [FILL_W-1:0]  fill_r;
  logic             req_r;
  logic [KEY_W-1:0] key_r;
  logic [WGT_W-1:0] wgt_r;
  logic             out_valid_r;
  logic             out_newly_hot_r;
  logic             out_is_hot_r;
  logic [ID_W-1:0]  out_hot_index_r;
  logic [KEY_W-1:0] out_key_echo_r;

  logic             row_we;
  logic [BKT_W-1:0] row_waddr;
  row_t             row_wdata;
  logic [BKT_W-1:0] row_raddr;
  row_t             row_rdata;
  logic             fifo_we;
  logic [FIFO_AW-1:0] fifo_waddr;
  logic [ID_W-1:0]  fifo_wdata;
  logic [ID_W-1:0]  fifo_rdata;
  logic [CNT_W-1:0] thr_cnt;
  logic             accept;
  logic             need_decay;
  logic [TOT_W:0]   total_sum;
  calc_t            res;
  slot_t            rel_slot;
  logic             rel;

  assign thr_cnt    = {{(CNT_W - THR_W - 8){1'b0}}, thr_r, 8'b0};
  assign limit      = TOT_W'(thr_r) * TOT_W'(LIMIT_MUL);
  assign accept     = start && (state_r == ST_IDLE);
  assign need_decay = (in_req_type == REQ_INSERT) && in_batch_first && (total_r > limit);
  assign total_sum  = {1'b0, total_r} + {{(TOT_W + 1 - WGT_W){1'b0}}, wgt_r};
  assign rel_slot   = dec_row_r[way_r];
  assign rel        = (rel_slot.id != '0) && (rel_slot.cnt < thr_cnt || rel_slot.cnt == '0);

  hkid_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BUCKETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  hkid_ram #(.WIDTH(ID_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .raddr (head_r),
    .rdata (fifo_rdata)
  );

  hkid_calc u_calc (
    .row        (row_rdata),
    .req_type   (req_r),
    .key        (key_r),
    .weight     (wgt_r),
    .thr        (thr_cnt),
    .fifo_empty (fill_r == '0),
    .head_id    (fifo_rdata),
    .res        (res)
  );

  always_comb begin
    row_raddr = (state_r == ST_IDLE) ? in_key[BKT_W-1:0] :
                (state_r == ST_MAIN_RD) ? key_r[BKT_W-1:0] : dec_bkt_r;
    row_we     = 1'b0;
    row_waddr  = key_r[BKT_W-1:0];
    row_wdata  = res.row;
    fifo_we    = 1'b0;
    fifo_waddr = tail_r;
    fifo_wdata = rel_slot.id;
    case (state_r)
      ST_CLEAR: begin
        row_we     = (clr_r < CLR_W'(NUM_BUCKETS - 1)) || (clr_r == CLR_W'(NUM_BUCKETS - 1));
        row_waddr  = clr_r[BKT_W-1:0];
        row_wdata  = '0;
        fifo_we    = (clr_r < CLR_W'(FIFO_DEPTH - 1)) || (clr_r == CLR_W'(FIFO_DEPTH - 1));
        fifo_waddr = clr_r[FIFO_AW-1:0];
        fifo_wdata = ID_W'(clr_r[FIFO_AW-1:0] + 1'b1);
      end
      ST_CALC: begin
        row_we = (req_r == REQ_INSERT);
      end
      ST_DEC_REL: begin
        fifo_we = rel && (fill_r < FILL_W'(FIFO_DEPTH));
      end
      ST_DEC_WR: begin
        row_we    = 1'b1;
        row_waddr = dec_bkt_r;
        row_wdata = dec_row_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_valid_r <= 1'b0;
    if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
    if (accept) begin
      req_r <= in_req_type;
      key_r <= in_key;
      wgt_r <= in_weight;
    end
    case (state_r)
      ST_CLEAR: begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == CLR_W'(CLR_N - 1)) begin
          state_r <= ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (need_decay) begin
            dec_bkt_r <= '0;
            state_r   <= ST_DEC_RD;
          end else begin
            state_r <= ST_CALC;
          end
        end
      end
      ST_CALC: begin
        out_valid_r     <= 1'b1;
        out_newly_hot_r <= res.newly_hot;
        out_is_hot_r    <= res.is_hot;
        out_hot_index_r <= res.hot_index;
        out_key_echo_r  <= res.key_echo;
        if (req_r == REQ_INSERT) begin
          total_r <= total_sum[TOT_W] ? {TOT_W{1'b1}} : total_sum[TOT_W-1:0];
        end
        if (res.take_id) begin
          head_r <= head_r + 1'b1;
          fill_r <= fill_r - 1'b1;
        end
        state_r <= ST_IDLE;
      end
      ST_DEC_RD: begin
        state_r <= ST_DEC_MUL;
      end
      ST_DEC_MUL: begin
        for (int i = 0; i < WAYS; i++) begin
          dec_row_r[i].key <= row_rdata[i].key;
          dec_row_r[i].id  <= row_rdata[i].id;
          dec_row_r[i].cnt <= CNT_W'(((CNT_W + DECAY_W)'(row_rdata[i].cnt) *
                                      (CNT_W + DECAY_W)'(DECAY_MUL)) >> DECAY_W);
        end
        way_r   <= '0;
        state_r <= ST_DEC_REL;
      end
      ST_DEC_REL: begin
        if (rel) begin
          dec_row_r[way_r].id <= '0;
          if (fill_r < FILL_W'(FIFO_DEPTH)) begin
            tail_r <= tail_r + 1'b1;
            fill_r <= fill_r + 1'b1;
          end
        end
        way_r <= way_r + 1'b1;
        if (way_r == WAY_W'(WAYS - 1)) begin
          state_r <= ST_DEC_WR;
        end
      end
      ST_DEC_WR: begin
        dec_bkt_r <= dec_bkt_r + 1'b1;
        if (dec_bkt_r == BKT_W'(NUM_BUCKETS - 1)) begin
          total_r <= '0;
          state_r <= ST_MAIN_RD;
        end else begin
          state_r <= ST_DEC_RD;
        end
      end
      ST_MAIN_RD: begin
        state_r <= ST_CALC;
      end
      default: begin
        state_r <= ST_IDLE;
      end
    endcase
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      thr_r       <= THR_W'(200);
      total_r     <= '0;
      head_r      <= '0;
      tail_r      <= FIFO_AW'(FIFO_DEPTH - 1);
      fill_r      <= FILL_W'(FIFO_DEPTH - 1);
      out_valid_r <= 1'b0;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_newly_hot = out_newly_hot_r;
  assign out_is_hot    = out_is_hot_r;
  assign out_hot_index = out_hot_index_r;
  assign out_key_echo  = out_key_echo_r;

endmodule

### tb/hkid_checker.sv
// Checker for the hot key sketch id allocator: watches both channels and the
// threshold write port, predicts every result and compares it field by field.
// Depends on hkid_pkg for sizes and request codes.
module hkid_checker import hkid_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic             in_req_type,
  input  logic [KEY_W-1:0] in_key,
  input  logic [WGT_W-1:0] in_weight,
  input  logic             in_batch_first,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  input  logic             out_valid,
  input  logic             out_newly_hot,
  input  logic             out_is_hot,
  input  logic [ID_W-1:0]  out_hot_index,
  input  logic [KEY_W-1:0] out_key_echo,
  output int               errors,
  output int               pending,
  output int               grants,
  output int               decays
);

  localparam int SLOTS = NUM_BUCKETS * WAYS;

  typedef struct packed {
    logic             newly_hot;
    logic             is_hot;
    logic [ID_W-1:0]  hot_index;
    logic [KEY_W-1:0] key_echo;
  } answer_t;

  logic [KEY_W-1:0]   key_mem [SLOTS];
  logic [CNT_W-1:0]   cnt_mem [SLOTS];
  logic [ID_W-1:0]    id_mem  [SLOTS];
  logic [ID_W-1:0]    id_pool [FIFO_DEPTH];
  int                 pool_head, pool_tail, pool_fill;
  logic [TOT_W-1:0]   total;
  logic [THR_W-1:0]   threshold;
  answer_t            answers [$];

  initial begin
    errors = 0;
    grants = 0;
    decays = 0;
    threshold = 16'd200;
    for (int i = 0; i < SLOTS; i++) begin
      key_mem[i] = '0;
      cnt_mem[i] = '0;
      id_mem[i] = '0;
    end
    for (int i = 0; i < FIFO_DEPTH; i++) id_pool[i] = (i < FIFO_DEPTH - 1) ? ID_W'(i + 1) : '0;
    pool_head = 0;
    pool_tail = FIFO_DEPTH - 1;
    pool_fill = FIFO_DEPTH - 1;
    total = '0;
  end

  assign pending = answers.size();

  function automatic logic [CNT_W-1:0] add_sat(logic [CNT_W-1:0] a, logic [WGT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + b;
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  task automatic free_id(logic [ID_W-1:0] id);
    if (pool_fill < FIFO_DEPTH) begin
      id_pool[pool_tail] = id;
      pool_tail = (pool_tail + 1) % FIFO_DEPTH;
      pool_fill++;
    end
  endtask

  task automatic decay_table();
    logic [CNT_W-1:0] thr_q;
    logic [CNT_W-1:0] nc;
    logic [63:0]      prod;
    thr_q = {8'd0, threshold, 8'd0};
    for (int i = 0; i < SLOTS; i++) begin
      prod = 64'(cnt_mem[i]) * DECAY_MUL;
      nc = prod[47:16];
      if (id_mem[i] != 0 && (nc < thr_q || nc == 0)) begin
        free_id(id_mem[i]);
        id_mem[i] = '0;
      end
      cnt_mem[i] = nc;
    end
    total = '0;
    decays++;
  endtask

  task automatic swap_slot(int a, int b);
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] c;
    logic [ID_W-1:0]  h;
    k = key_mem[a]; c = cnt_mem[a]; h = id_mem[a];
    key_mem[a] = key_mem[b]; cnt_mem[a] = cnt_mem[b]; id_mem[a] = id_mem[b];
    key_mem[b] = k; cnt_mem[b] = c; id_mem[b] = h;
  endtask

  task automatic insert_key(logic [KEY_W-1:0] key, logic [WGT_W-1:0] w, output logic hot);
    int               base;
    int               s;
    logic [TOT_W:0]   t;
    logic [CNT_W-1:0] thr_q;
    base = int'(key[BKT_W-1:0]) * WAYS;
    thr_q = {8'd0, threshold, 8'd0};
    hot = 1'b0;
    t = {1'b0, total} + w;
    total = t[TOT_W] ? '1 : t[TOT_W-1:0];
    for (int i = 0; i < WAYS; i++) begin
      s = base + i;
      if (cnt_mem[s] != 0 && key_mem[s] == key) begin
        cnt_mem[s] = add_sat(cnt_mem[s], w);
        if (cnt_mem[s] >= thr_q && pool_fill != 0 && id_mem[s] == 0) begin
          id_mem[s] = id_pool[pool_head];
          pool_head = (pool_head + 1) % FIFO_DEPTH;
          pool_fill--;
          hot = 1'b1;
          grants++;
        end
        for (int j = i; j > 0 && cnt_mem[base + j] > cnt_mem[base + j - 1]; j--)
          swap_slot(base + j, base + j - 1);
        return;
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      s = base + i;
      if (cnt_mem[s] == 0) begin
        cnt_mem[s] = 32'(w);
        key_mem[s] = key;
        return;
      end
    end
    if (id_mem[base + 3] == 0) begin
      cnt_mem[base + 3] = add_sat(cnt_mem[base + 3], w);
      key_mem[base + 3] = key;
    end
  endtask

  task automatic predict(logic req, logic [KEY_W-1:0] key, logic [WGT_W-1:0] w, logic first);
    answer_t a;
    longint  limit;
    int      base;
    logic    hot;
    a = '0;
    if (req == REQ_INSERT) begin
      limit = LIMIT_MUL * longint'(threshold);
      if (first && longint'(total) > limit) decay_table();
      insert_key(key, w, hot);
      a.newly_hot = hot;
    end else begin
      base = int'(key[BKT_W-1:0]) * WAYS;
      a.key_echo = key;
      for (int i = 0; i < WAYS; i++) begin
        if (cnt_mem[base + i] != 0 && key_mem[base + i] == key && id_mem[base + i] != 0) begin
          a.is_hot = 1'b1;
          a.hot_index = id_mem[base + i];
          a.key_echo = '0;
          break;
        end
      end
    end
    answers.insert(answers.size(), a);
  endtask

  always @(posedge clk) begin
    answer_t e;
    if (rst_n) begin
      if (out_valid) begin
        if (answers.size() == 0) begin
          $display("%0t: result with none expected: newly_hot %b is_hot %b index %0d echo %h",
                   $time, out_newly_hot, out_is_hot, out_hot_index, out_key_echo);
          errors++;
        end else begin
          e = answers.pop_front();
          if (out_newly_hot !== e.newly_hot) begin
            $display("%0t: newly_hot expected %b actual %b", $time, e.newly_hot, out_newly_hot);
            errors++;
          end
          if (out_is_hot !== e.is_hot) begin
            $display("%0t: is_hot expected %b actual %b", $time, e.is_hot, out_is_hot);
            errors++;
          end
          if (out_hot_index !== e.hot_index) begin
            $display("%0t: hot_index expected %0d actual %0d", $time, e.hot_index,
                     out_hot_index);
            errors++;
          end
          if (out_key_echo !== e.key_echo) begin
            $display("%0t: key_echo expected %h actual %h", $time, e.key_echo, out_key_echo);
            errors++;
          end
        end
      end
      if (cfg_we) threshold = cfg_wdata;
      if (start && !busy) predict(in_req_type, in_key, in_weight, in_batch_first);
    end
  end

endmodule

### tb/testbench.sv
// Top of the testbench: clock, reset, stimulus, watchdog and verdict.
// Depends on hkid_pkg, hkid_checker and the hot_key_sketch_id_allocator block.
module testbench;
  import hkid_pkg::*;

  localparam int STALL_LIMIT = 100000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_req_type = REQ_INSERT;
  logic [KEY_W-1:0] in_key = '0;
  logic [WGT_W-1:0] in_weight = '0;
  logic             in_batch_first = 1'b0;
  logic             cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;
  logic             out_valid, out_newly_hot, out_is_hot;
  logic [ID_W-1:0]  out_hot_index;
  logic [KEY_W-1:0] out_key_echo;
  int               errors, pending, grants, decays;
  int               stall_cycles = 0;
  int               inserts = 0, queries = 0;
  bit               gaps_on = 1'b1;

  always #5 clk = ~clk;

  hot_key_sketch_id_allocator u_top (.*);

  hkid_checker u_checker (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(logic req, logic [KEY_W-1:0] key, logic [WGT_W-1:0] w, logic first);
    start <= 1'b1;
    in_req_type <= req;
    in_key <= key;
    in_weight <= w;
    in_batch_first <= first;
    if (req == REQ_INSERT) inserts++;
    else queries++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 13)) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    logic [BKT_W-1:0] bkt;
    case ($urandom_range(0, 3))
      0: bkt = '0;
      1: bkt = '1;
      2: bkt = BKT_W'($urandom_range(16, 23));
      default: bkt = BKT_W'($urandom);
    endcase
    if ($urandom_range(0, 9) < 7) return {20'($urandom_range(0, 5)), bkt};
    return $urandom;
  endfunction

  function automatic logic [WGT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return WGT_W'($urandom_range(128, 512));
      default: return WGT_W'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic req;
    for (int i = 0; i < n; i++) begin
      if (gaps_on && $urandom_range(0, 3) == 0) gap();
      req = ($urandom_range(0, 9) < 3) ? REQ_QUERY : REQ_INSERT;
      send(req, pick_key(), pick_weight(), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] k1, k2, k3, k4, k5, k6;
    k1 = {20'd1, 12'h005}; k2 = {20'd2, 12'h005}; k3 = {20'd3, 12'h005};
    k4 = {20'd4, 12'h005}; k5 = {20'd5, 12'h005}; k6 = {20'd6, 12'h005};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    set_threshold(16'd1);

    send(REQ_QUERY, k1, 16'd0, 1'b0);
    send(REQ_INSERT, k1, 16'd0, 1'b0);
    send(REQ_QUERY, k1, 16'd0, 1'b1);
    send(REQ_INSERT, k1, 16'd256, 1'b0);
    send(REQ_INSERT, k1, 16'd256, 1'b0);
    send(REQ_QUERY, k1, 16'd7, 1'b0);
    send(REQ_INSERT, k2, 16'd128, 1'b0);
    send(REQ_INSERT, k3, 16'd128, 1'b0);
    send(REQ_INSERT, k4, 16'd128, 1'b0);
    send(REQ_INSERT, k5, 16'd100, 1'b0);
    send(REQ_QUERY, k4, 16'd0, 1'b0);
    send(REQ_INSERT, k5, 16'hFFFF, 1'b0);
    send(REQ_QUERY, k5, 16'd0, 1'b0);
    send(REQ_INSERT, k6, 16'hFFFF, 1'b0);
    send(REQ_INSERT, k6, 16'hFFFF, 1'b0);
    send(REQ_QUERY, k6, 16'hFFFF, 1'b1);
    send(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send(REQ_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send(REQ_QUERY, 32'hFFFF_FFFF, 16'd0, 1'b0);
    send(REQ_INSERT, 32'h0, 16'hFFFF, 1'b0);
    send(REQ_QUERY, 32'h0, 16'hFFFF, 1'b1);
    send(REQ_INSERT, k1, 16'd1, 1'b0);

    random_phase(350);
    set_threshold(16'hFFFF);
    random_phase(350);
    set_threshold(16'd200);
    random_phase(350);
    set_threshold(16'($urandom_range(2, 50)));
    random_phase(350);
    set_threshold(16'd1);
    gaps_on = 1'b0;
    random_phase(350);

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d inserts and %0d queries over five thresholds", inserts, queries);
    $display("%0d hot ids granted, %0d table decays", grants, decays);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
